// ----- rtl/core/tccw_pkg.sv -----
// Package for the text console cell writer: sizes, codes, FSM and command types.
package tccw_pkg;

    localparam int ROWS       = 25;
    localparam int COLS       = 80;
    localparam int CELL_COUNT = ROWS * COLS;
    localparam int KEEP_COUNT = CELL_COUNT - COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;

    localparam logic [1:0] OP_PUT       = 2'd0;
    localparam logic [1:0] OP_BACKSPACE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_SCR_CLR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scroll_init;
        logic move_rd;
        logic move_wr;
        logic clr_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cursor_over;
        logic move_last;
        logic clr_last;
    } t_dp_status;

endpackage

// ----- rtl/core/tccw_ctrl.sv -----
// Controller FSM for the text console cell writer.
module tccw_ctrl import tccw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        unique case (r_state)
            ST_INIT_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.cursor_over) begin
                    o_cmd.scroll_init = 1'b1;
                    n_state           = ST_MOVE_RD;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = i_status.move_last ? ST_SCR_CLR : ST_MOVE_RD;
            end
            ST_SCR_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && w_out_free) |=> o_out_valid)
        else $error("response not presented");

    a_check_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_CHECK))
        else $error("exec not followed by check");

endmodule

// ----- rtl/core/tccw_datapath.sv -----
// Datapath for the text console cell writer: screen memory, cursor, attribute, result.
module tccw_datapath import tccw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_char_code,
    input  logic [10:0]      i_read_index,
    input  logic             i_cfg_wr,
    input  logic [7:0]       i_cfg_data,
    output logic [10:0]      o_cursor_position,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr,
    output logic             o_scrolled
);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [1:0]        r_op;
    logic [7:0]        r_char;
    logic [POS_W-1:0]  r_ridx;
    logic [POS_W-1:0]  r_cursor;
    logic [COL_W-1:0]  r_col;
    logic [7:0]        r_attr;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_hit;
    logic              r_scrolled;
    logic [CELL_W-1:0] r_rdata;
    logic [POS_W-1:0]  r_out_cursor;
    logic [7:0]        r_out_char;
    logic [7:0]        r_out_attr;
    logic              r_out_scrolled;

    logic              w_put_char, w_put_nl, w_bs, w_rd;
    logic [POS_W-1:0]  w_cursor_dec;
    logic [POS_W-1:0]  w_cursor_nl;
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [CELL_W-1:0] w_wdata;

    assign w_put_char   = (r_op == OP_PUT) && (r_char != CHAR_NUL) && (r_char != CHAR_NEWLINE);
    assign w_put_nl     = (r_op == OP_PUT) && (r_char == CHAR_NEWLINE);
    assign w_bs         = (r_op == OP_BACKSPACE) && (r_cursor != '0);
    assign w_rd         = (r_op == OP_READ) && (r_ridx < POS_W'(CELL_COUNT));
    assign w_cursor_dec = r_cursor - POS_W'(1);
    assign w_cursor_nl  = r_cursor + POS_W'(COLS) - POS_W'(r_col);

    // memory port steering
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_addr;
        w_raddr = r_addr + ADDR_W'(COLS);
        w_wdata = '0;
        if (i_cmd.exec) begin
            if (w_put_char) begin
                w_we    = 1'b1;
                w_waddr = r_cursor[ADDR_W-1:0];
                w_wdata = {r_attr, r_char};
            end else if (w_bs) begin
                w_we    = 1'b1;
                w_waddr = w_cursor_dec[ADDR_W-1:0];
                w_wdata = {r_attr, CHAR_SPACE};
            end else if (w_rd) begin
                w_re    = 1'b1;
                w_raddr = r_ridx[ADDR_W-1:0];
            end
        end else if (i_cmd.move_rd) begin
            w_re = 1'b1;
        end else if (i_cmd.move_wr) begin
            w_we    = 1'b1;
            w_wdata = r_rdata;
        end else if (i_cmd.clr_wr) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_attr   <= ATTR_RESET;
            r_addr   <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                if (w_put_char) begin
                    r_cursor <= r_cursor + POS_W'(1);
                    r_col    <= (r_col == COL_W'(COLS - 1)) ? '0 : r_col + COL_W'(1);
                end else if (w_put_nl) begin
                    r_cursor <= w_cursor_nl;
                    r_col    <= '0;
                end else if (w_bs) begin
                    r_cursor <= w_cursor_dec;
                    r_col    <= (r_col == '0) ? COL_W'(COLS - 1) : r_col - COL_W'(1);
                end
            end
            if (i_cmd.scroll_init) begin
                r_cursor <= r_cursor - POS_W'(COLS);
                r_addr   <= '0;
            end else if (i_cmd.move_wr) begin
                r_addr <= r_addr + ADDR_W'(1);
            end else if (i_cmd.clr_wr) begin
                // wraps to zero after the last cell, ready for the next pass
                r_addr <= o_status.clr_last ? '0 : r_addr + ADDR_W'(1);
            end
        end
    end

    // request capture and result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_char     <= i_char_code;
            r_ridx     <= i_read_index;
            r_rd_hit   <= 1'b0;
            r_scrolled <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_rd_hit <= w_rd;
        end
        if (i_cmd.scroll_init) begin
            r_scrolled <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_cursor   <= r_cursor;
            r_out_char     <= r_rd_hit ? r_rdata[7:0] : 8'd0;
            r_out_attr     <= r_rd_hit ? r_rdata[15:8] : 8'd0;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_status.cursor_over = (r_cursor >= POS_W'(CELL_COUNT));
    assign o_status.move_last   = (r_addr == ADDR_W'(KEEP_COUNT - 1));
    assign o_status.clr_last    = (r_addr == ADDR_W'(CELL_COUNT - 1));

    assign o_cursor_position = r_out_cursor;
    assign o_cell_char       = r_out_char;
    assign o_cell_attr       = r_out_attr;
    assign o_scrolled        = r_out_scrolled;

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= POS_W'(CELL_COUNT))
        else $error("cursor beyond one past last cell");

    a_exec_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (r_cursor < POS_W'(CELL_COUNT)))
        else $error("request executed with cursor out of range");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLS - 1))
        else $error("column counter out of range");

    a_scroll_realigns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scroll_init |=> (r_cursor == POS_W'(KEEP_COUNT)) && (r_col == '0))
        else $error("cursor not at last row start after scroll");

endmodule

// ----- rtl/core/text_console_cell_writer_unit.sv -----
// Text console cell writer: top level joining controller and datapath.
//
// Keeps a ROWS x COLS screen of 16-bit cells (attribute high byte, char low
// byte) plus a cursor. Input channel: i_in_valid / o_in_stall with
// i_opcode, i_char_code, i_read_index; a request is taken when valid is
// high and stall is low. Output channel: o_out_valid / i_out_stall with
// o_cursor_position, o_cell_char, o_cell_attr, o_scrolled; exactly one
// result per request. Config channel: i_cfg_valid / o_cfg_ready with
// i_cfg_data writes text_attribute (reset 0x0F); ready is always high.
//
// One request is in flight at a time. For put, backspace and read the
// controller steps through its fixed state sequence (capture, execute,
// check, respond) and takes the next request only once back in idle. A put
// that runs off the last cell scrolls: each kept cell is read and then
// written one row up, and then each cell of the bottom row is cleared.
// After reset the screen is cleared one cell a cycle, all CELL_COUNT = 2000
// cells, with o_in_stall high; config writes are taken meanwhile.
// The result sits in an output register; a stalled receiver holds it and
// the next request is accepted, but its result waits until the slot frees.
module text_console_cell_writer_unit import tccw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_cursor_position,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    output logic        o_scrolled,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_wr;

    // attribute register is free to update at any time
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tccw_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_read_index      (i_read_index),
        .i_cfg_wr          (w_cfg_wr),
        .i_cfg_data        (i_cfg_data),
        .o_cursor_position (o_cursor_position),
        .o_cell_char       (o_cell_char),
        .o_cell_attr       (o_cell_attr),
        .o_scrolled        (o_scrolled)
    );

endmodule

// ----- sim/text_console_cell_writer_unit_tb.sv -----
// Self-checking testbench for the text console cell writer: screen model, scoreboard, driver.
`timescale 1ns / 1ps

typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
} t_console_result;

// Mirrors the screen, cursor and attribute; queues one response per request.
class console_scoreboard;
    logic [15:0]     cells [tccw_pkg::CELL_COUNT];
    int unsigned     cursor;
    logic [7:0]      attribute;
    t_console_result awaited[$];
    int              errors;

    function new();
        foreach (cells[i]) cells[i] = '0;
        cursor    = 0;
        attribute = tccw_pkg::ATTR_RESET;
        errors    = 0;
    endfunction

    function void write_cell(int unsigned idx, logic [7:0] ch);
        cells[idx] = {attribute, ch};
    endfunction

    function void apply_request(logic [1:0] op, logic [7:0] ch, logic [10:0] ridx);
        t_console_result want;
        want = '0;
        case (op)
            tccw_pkg::OP_PUT: begin
                if (ch != tccw_pkg::CHAR_NUL) begin
                    if (ch == tccw_pkg::CHAR_NEWLINE) begin
                        cursor = cursor + tccw_pkg::COLS - (cursor % tccw_pkg::COLS);
                    end else begin
                        write_cell(cursor, ch);
                        cursor++;
                    end
                    // Ran off the last cell: shift rows up, blank the bottom row.
                    if (cursor >= tccw_pkg::CELL_COUNT) begin
                        for (int i = 0; i < tccw_pkg::KEEP_COUNT; i++)
                            cells[i] = cells[i + tccw_pkg::COLS];
                        for (int i = tccw_pkg::KEEP_COUNT; i < tccw_pkg::CELL_COUNT; i++)
                            cells[i] = '0;
                        cursor -= tccw_pkg::COLS;
                        want.scrolled = 1'b1;
                    end
                end
            end
            tccw_pkg::OP_BACKSPACE: begin
                if (cursor > 0) begin
                    cursor--;
                    write_cell(cursor, tccw_pkg::CHAR_SPACE);
                end
            end
            tccw_pkg::OP_READ: begin
                if (int'(ridx) < tccw_pkg::CELL_COUNT) begin
                    want.cell_char = cells[ridx][7:0];
                    want.cell_attr = cells[ridx][15:8];
                end
            end
            default: ;
        endcase
        want.cursor_position = cursor[10:0];
        awaited.push_back(want);
    endfunction

    function void check_result(t_console_result got);
        t_console_result want;
        if (awaited.size() == 0) begin
            $error("unexpected response: cursor_position %0d", got.cursor_position);
            errors++;
            return;
        end
        want = awaited.pop_front();
        if (got.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, actual %0d",
                   want.cursor_position, got.cursor_position);
            errors++;
        end
        if (got.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0h, actual %0h", want.cell_char, got.cell_char);
            errors++;
        end
        if (got.cell_attr !== want.cell_attr) begin
            $error("cell_attr: expected %0h, actual %0h", want.cell_attr, got.cell_attr);
            errors++;
        end
        if (got.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0b, actual %0b", want.scrolled, got.scrolled);
            errors++;
        end
    endfunction
endclass

module text_console_cell_writer_unit_tb;
    import tccw_pkg::*;

    // Opcode 3 has no meaning; the block must leave state alone and answer a zero cell with the current cursor.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Worst case is every request scrolling plus stalls, many times over.
    localparam int CYCLE_LIMIT    = 20_000_000;
    localparam int PHASE_REQUESTS = 125;
    localparam int SETTLE_CYCLES  = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_char_code;
    logic [10:0] i_read_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [10:0] o_cursor_position;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_attr;
    logic        o_scrolled;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    console_scoreboard sb;
    t_console_result   seen_result;
    int                send_idle_pct;
    int                out_stall_pct;
    int                cycle_count;

    text_console_cell_writer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_read_index      (i_read_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_position (o_cursor_position),
        .o_cell_char       (o_cell_char),
        .o_cell_attr       (o_cell_attr),
        .o_scrolled        (o_scrolled),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver side: random stall at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Both handshakes sampled at the edge. Responses are checked before the
    // request at the same edge is noted, so a response can never match a
    // request taken in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_result = '{o_cursor_position, o_cell_char, o_cell_attr, o_scrolled};
                sb.check_result(seen_result);
            end
            if (i_in_valid && !o_in_stall)
                sb.apply_request(i_opcode, i_char_code, i_read_index);
        end
    end

    // Hang guard.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("text_console_cell_writer_unit_tb failed");
        $finish;
    end

    // Present one request and hold it until the block takes it. Returns at
    // the accepting edge with valid still high, so the caller either chains
    // the next request or drops valid in that same step.
    task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                                input logic [10:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_char_code  <= ch;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Sender drops valid and pauses until every response is back, then lets the block settle.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Attribute write; only called with the block idle.
    task automatic write_attribute(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.attribute = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Picks a read index: mostly around the cursor or anywhere on screen,
    // sometimes past the last cell.
    function automatic logic [10:0] pick_read_index();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return (sb.cursor >= 4) ? 11'(sb.cursor - $urandom_range(1, 4)) : 11'd0;
        if (sel < 9)
            return 11'($urandom_range(CELL_COUNT - 1));
        return 11'($urandom_range(2047, CELL_COUNT));
    endfunction

    int send_pcts [4] = '{0, 53, 0, 17};
    int stall_pcts[4] = '{0, 0, 53, 17};

    initial begin
        int          sent;
        int unsigned kind;
        int unsigned run_len;

        sb            = new();
        send_idle_pct = 0;
        out_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_PUT;
        i_char_code   = CHAR_NUL;
        i_read_index  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, still at the reset attribute. The block clears its
        // screen first; the stall holds the first request off meanwhile.
        send_request(OP_BACKSPACE, 8'd0, 11'd0);       // backspace at cursor zero
        send_request(OP_READ, 8'd0, 11'd0);            // cleared screen reads zero
        send_request(OP_PUT, CHAR_NUL, 11'd2047);      // zero byte is ignored
        send_request(OP_PUT, 8'd65, 11'd0);
        send_request(OP_PUT, 8'd255, 11'd1999);
        send_request(OP_PUT, 8'd1, 11'd0);
        send_request(OP_READ, 8'd0, 11'd1);
        send_request(OP_READ, 8'd255, 11'd2047);       // past the last cell
        send_request(OP_READ, 8'd0, 11'(CELL_COUNT));  // first index past the end
        send_request(OP_READ, 8'd0, 11'(CELL_COUNT - 1));
        send_request(OP_PUT, CHAR_NEWLINE, 11'd0);
        send_request(OP_PUT, 8'd126, 11'd0);
        send_request(OP_BACKSPACE, 8'd255, 11'd2047);
        send_request(OP_BACKSPACE, 8'd0, 11'd0);       // crosses back into row 0
        send_request(OP_READ, 8'd0, 11'(COLS));
        send_request(OP_READ, 8'd0, 11'(COLS - 1));
        send_request(OP_UNUSED, 8'd255, 11'd2047);
        send_request(OP_UNUSED, CHAR_NEWLINE, 11'd0);
        wait_for_idle();

        write_attribute(8'h00);
        send_request(OP_PUT, 8'd66, 11'd0);
        send_request(OP_BACKSPACE, 8'd0, 11'd0);       // space takes the new attribute
        send_request(OP_READ, 8'd0, 11'(sb.cursor));
        wait_for_idle();

        write_attribute(8'hFF);
        send_request(OP_PUT, 8'd200, 11'd0);
        send_request(OP_READ, 8'd0, 11'(sb.cursor - 1));
        send_request(OP_PUT, CHAR_NEWLINE, 11'd0);
        wait_for_idle();

        // Random part: text runs, line breaks, backspaces and reads, with a
        // little noise. Long runs wrap lines and reach scrolls by either path.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pcts[phase];
            out_stall_pct = stall_pcts[phase];
            write_attribute((phase == 3) ? 8'h0F : 8'($urandom_range(255)));
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    run_len = ($urandom_range(9) == 0) ? $urandom_range(70, 90)
                                                       : $urandom_range(1, 12);
                    if (run_len > PHASE_REQUESTS - sent)
                        run_len = PHASE_REQUESTS - sent;
                    repeat (run_len)
                        send_request(OP_PUT, 8'($urandom_range(1, 255)),
                                     11'($urandom_range(2047)));
                    sent += run_len;
                end else if (kind < 65) begin
                    run_len = $urandom_range(1, 4);
                    if (run_len > PHASE_REQUESTS - sent)
                        run_len = PHASE_REQUESTS - sent;
                    repeat (run_len)
                        send_request(OP_PUT, CHAR_NEWLINE, 11'($urandom_range(2047)));
                    sent += run_len;
                end else if (kind < 75) begin
                    run_len = $urandom_range(1, 4);
                    if (run_len > PHASE_REQUESTS - sent)
                        run_len = PHASE_REQUESTS - sent;
                    repeat (run_len)
                        send_request(OP_BACKSPACE, 8'($urandom_range(255)),
                                     11'($urandom_range(2047)));
                    sent += run_len;
                end else if (kind < 92) begin
                    send_request(OP_READ, 8'($urandom_range(255)), pick_read_index());
                    sent++;
                end else begin
                    send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                                 11'($urandom_range(2047)));
                    sent++;
                end
            end
            // Drain between phases so the next attribute write lands idle.
            wait_for_idle();
        end

        if (sb.errors == 0) begin
            $display("text_console_cell_writer_unit_tb passed");
        end else begin
            $display("text_console_cell_writer_unit_tb failed");
        end
        $finish;
    end
endmodule
